// File: rtl/assert_macros.svh
// Assertion macros shared by the angular size cull RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or condition at every clock edge out of reset.
`define IASC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in this cycle implies another in the next cycle.
`define IASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/iasc_pkg.sv
// Package for the angular size cull block: transaction types and codes.
// Depends on nothing; imported by the top module and the bench, not by the multiplier lane.
`default_nettype none

package iasc_pkg;

	localparam int WORD_BITS    = 32;
	localparam int EYE_BITS     = 32;
	localparam int NEAR_BITS    = 31;
	localparam int THR_BITS     = 16;
	localparam int REG_IDX_BITS = 3;
	localparam int CFG_BITS     = 32;
	localparam int REASON_BITS  = 3;

	// Configuration register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_CULL_ENABLE = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_EYE_X       = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_EYE_Y       = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_EYE_Z       = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_NEAR_KEEP   = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_ANGLE   = 3'd5;

	// Item kinds and matrix groups
	localparam logic       KIND_BOUNDS       = 1'b0;
	localparam logic       KIND_MATRIX       = 1'b1;
	localparam logic [1:0] GROUP_COL0        = 2'd0;
	localparam logic [1:0] GROUP_COL1        = 2'd1;
	localparam logic [1:0] GROUP_COL2        = 2'd2;
	localparam logic [1:0] GROUP_TRANSLATION = 2'd3;

	// Decision reasons
	localparam logic [REASON_BITS-1:0] REASON_DISABLED  = 3'd0;
	localparam logic [REASON_BITS-1:0] REASON_NO_BOUNDS = 3'd1;
	localparam logic [REASON_BITS-1:0] REASON_NEAR      = 3'd2;
	localparam logic [REASON_BITS-1:0] REASON_SMALL     = 3'd3;
	localparam logic [REASON_BITS-1:0] REASON_LARGE     = 3'd4;

	typedef struct packed {
		logic                        kind;
		logic [1:0]                  group_index;
		logic signed [WORD_BITS-1:0] word0;
		logic signed [WORD_BITS-1:0] word1;
		logic signed [WORD_BITS-1:0] word2;
		logic signed [WORD_BITS-1:0] word3;
	} iasc_in_t;

	typedef struct packed {
		logic                   visible;
		logic [REASON_BITS-1:0] decision_reason;
	} iasc_out_t;

endpackage

`default_nettype wire

// File: rtl/iasc_mul_lane.sv
// One multiplier lane: signed shift-add multiply, one multiplier bit per cycle.
// Depends on assert_macros.svh; no package types.
`default_nettype none
`include "assert_macros.svh"

module iasc_mul_lane #(
	parameter int A_BITS = 8,
	parameter int B_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [A_BITS-1:0]         a,
	input  logic signed [B_BITS-1:0]         b,
	output logic                             done,
	output logic signed [A_BITS+B_BITS-1:0]  p
);

	localparam int P_BITS   = A_BITS + B_BITS;
	localparam int CNT_BITS = $clog2(B_BITS);

	logic [A_BITS-1:0]   a_mag;
	logic [B_BITS-1:0]   b_mag;
	logic [P_BITS-1:0]   mcand_q;
	logic [B_BITS-1:0]   mplier_q;
	logic [P_BITS-1:0]   acc_q;
	logic                neg_q;
	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;

	// Take magnitudes; the sign is applied at the end
	assign a_mag = a[A_BITS-1] ? (~a + A_BITS'(1)) : a;
	assign b_mag = b[B_BITS-1] ? (~b + B_BITS'(1)) : b;

	// Step counter and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= CNT_BITS'(cnt_q + 1'b1);
				if (cnt_q == CNT_BITS'(B_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= P_BITS'(a_mag);
			mplier_q <= b_mag;
			acc_q    <= '0;
			neg_q    <= a[A_BITS-1] ^ b[B_BITS-1];
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = neg_q ? $signed(-acc_q) : $signed(acc_q);

	`IASC_ASSERT(a_lane_done_after_run, clk, arst_n, done_q |-> $past(run_q), "lane done without a run")
	`IASC_ASSERT(a_lane_no_restart, clk, arst_n, start |-> !run_q, "lane restarted while running")

endmodule

`default_nettype wire

// File: rtl/instance_angular_size_cull.sv
// Angular size cull: bounds, matrix groups 0..2 and config writes are registered directly.
// A translation group runs 12 rounds on three multiplier lanes, whose B operand is
// LB bits wide, the transformed-coordinate width (66 at FRAC_BITS=16).
// One instance at a time: busy refuses all commands until the result is strobed.
// Reset clears registers, bounds and control; matrix words are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module instance_angular_size_cull #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  iasc_pkg::iasc_in_t                   cmd,
	output logic                                 done,
	output iasc_pkg::iasc_out_t                  result,
	input  logic                                 wr_en,
	input  logic [iasc_pkg::REG_IDX_BITS-1:0]    wr_idx,
	input  logic [iasc_pkg::CFG_BITS-1:0]        wr_data
);

	import iasc_pkg::*;

	localparam int W     = WORD_BITS;
	localparam int EW    = ((W > EYE_BITS) ? W : EYE_BITS) + 1;
	localparam int SHW   = EW + FRAC_BITS;
	localparam int AW    = ((SHW > 2 * W) ? SHW : 2 * W) + 2;
	localparam int DW    = 2 * AW + 1;
	localparam int DOTW  = 2 * W + 1;
	localparam int ROWW  = 2 * W + 2;
	localparam int R2W   = 2 * W;
	localparam int N2W   = 2 * NEAR_BITS;
	localparam int T2W   = 2 * THR_BITS;
	localparam int NSH   = 2 * FRAC_BITS;
	// lane widths: A carries distance squared, B the transformed coordinate
	localparam int LA    = DW;
	localparam int LB    = AW;
	localparam int P     = LA + LB;
	localparam int NW    = ((DW > N2W + NSH) ? DW : N2W + NSH) + 1;
	localparam int CW    = P + T2W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [3:0] R_D00  = 4'd0;
	localparam logic [3:0] R_D01  = 4'd1;
	localparam logic [3:0] R_D02  = 4'd2;
	localparam logic [3:0] R_D11  = 4'd3;
	localparam logic [3:0] R_D12  = 4'd4;
	localparam logic [3:0] R_D22  = 4'd5;
	localparam logic [3:0] R_A0   = 4'd6;
	localparam logic [3:0] R_A1   = 4'd7;
	localparam logic [3:0] R_A2   = 4'd8;
	localparam logic [3:0] R_DIST = 4'd9;
	localparam logic [3:0] R_SQ   = 4'd10;
	localparam logic [3:0] R_FIN  = 4'd11;

	// configuration
	logic                       cull_en_q;
	logic signed [EYE_BITS-1:0] eye_q [3];
	logic [NEAR_BITS-1:0]       near_q;
	logic [THR_BITS-1:0]        thr_q;

	// bounds and matrix
	logic signed [W-1:0]        center_q [3];
	logic signed [W-1:0]        radius_q;
	logic signed [W-1:0]        mat_q [3][3];

	// working values
	logic signed [AW-1:0]       acc_q [3];
	logic [ROWW-1:0]            row_q [3];
	logic [ROWW-1:0]            bound_q;
	logic [DW-1:0]              dist2_q;
	logic [R2W-1:0]             r2_q;
	logic [N2W-1:0]             near2_q;
	logic [T2W-1:0]             thr2_q;
	logic [P-1:0]               lhs_q;
	logic [P-1:0]               rhs_q;

	logic [1:0]                 state_q;
	logic [3:0]                 rnd_q;
	logic                       done_q;
	iasc_out_t                  res_q;

	logic                       accept;
	logic                       merge;
	logic                       lane_start;
	logic signed [LA-1:0]       lane_a [3];
	logic signed [LB-1:0]       lane_b [3];
	logic signed [P-1:0]        lane_p [3];
	logic [2:0]                 lane_done;

	logic signed [DOTW-1:0]     dot_sum;
	logic [ROWW-1:0]            dot_abs;
	logic signed [DW-1:0]       dist_sum;
	logic [ROWW-1:0]            bound_c;
	logic                       radius_pos;
	logic                       near_hit;
	logic                       keep_large;
	iasc_out_t                  decision;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign lane_start = (state_q == ST_ISSUE);
	assign merge      = (state_q == ST_WAIT) && lane_done[0];

	// Select lane operands for the current round
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lane_a[k] = '0;
			lane_b[k] = '0;
		end
		case (rnd_q)
			R_D00: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[0][k]);
				lane_b[k] = LB'(mat_q[0][k]);
			end
			R_D01: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[0][k]);
				lane_b[k] = LB'(mat_q[1][k]);
			end
			R_D02: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[0][k]);
				lane_b[k] = LB'(mat_q[2][k]);
			end
			R_D11: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[1][k]);
				lane_b[k] = LB'(mat_q[1][k]);
			end
			R_D12: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[1][k]);
				lane_b[k] = LB'(mat_q[2][k]);
			end
			R_D22: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[2][k]);
				lane_b[k] = LB'(mat_q[2][k]);
			end
			R_A0: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[0][k]);
				lane_b[k] = LB'(center_q[0]);
			end
			R_A1: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[1][k]);
				lane_b[k] = LB'(center_q[1]);
			end
			R_A2: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(mat_q[2][k]);
				lane_b[k] = LB'(center_q[2]);
			end
			R_DIST: for (int k = 0; k < 3; k++) begin
				lane_a[k] = LA'(acc_q[k]);
				lane_b[k] = acc_q[k];
			end
			R_SQ: begin
				lane_a[0] = LA'(radius_q);
				lane_b[0] = LB'(radius_q);
				lane_a[1] = LA'(near_q);
				lane_b[1] = LB'(near_q);
				lane_a[2] = LA'(thr_q);
				lane_b[2] = LB'(thr_q);
			end
			R_FIN: begin
				lane_a[0] = LA'(bound_q);
				lane_b[0] = LB'(r2_q);
				lane_a[2] = LA'(dist2_q);
				lane_b[2] = LB'(thr2_q);
			end
			default: ;
		endcase
	end

	// Three multiplier lanes
	for (genvar k = 0; k < 3; k++) begin : g_lane
		iasc_mul_lane #(
			.A_BITS(LA),
			.B_BITS(LB)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.start (lane_start),
			.a     (lane_a[k]),
			.b     (lane_b[k]),
			.done  (lane_done[k]),
			.p     (lane_p[k])
		);
	end

	// Merge lane products
	assign dot_sum  = DOTW'(lane_p[0]) + DOTW'(lane_p[1]) + DOTW'(lane_p[2]);
	assign dot_abs  = dot_sum[DOTW-1] ? ROWW'(-dot_sum) : ROWW'(dot_sum);
	assign dist_sum = DW'(lane_p[0]) + DW'(lane_p[1]) + DW'(lane_p[2]);

	// Largest absolute row sum of the Gram matrix
	always_comb begin
		bound_c = row_q[0];
		if (row_q[1] > bound_c) begin
			bound_c = row_q[1];
		end
		if (row_q[2] > bound_c) begin
			bound_c = row_q[2];
		end
	end

	// Decide in priority order
	assign radius_pos = !radius_q[W-1] && (|radius_q);
	assign near_hit   = NW'(dist2_q) <= NW'({near2_q, {NSH{1'b0}}});
	assign keep_large = {lhs_q, {T2W{1'b0}}} >= CW'(rhs_q);

	always_comb begin
		if (!cull_en_q) begin
			decision = '{visible: 1'b1, decision_reason: REASON_DISABLED};
		end else if (!radius_pos || (bound_q == '0)) begin
			decision = '{visible: 1'b1, decision_reason: REASON_NO_BOUNDS};
		end else if (near_hit) begin
			decision = '{visible: 1'b1, decision_reason: REASON_NEAR};
		end else if (keep_large) begin
			decision = '{visible: 1'b1, decision_reason: REASON_LARGE};
		end else begin
			decision = '{visible: 1'b0, decision_reason: REASON_SMALL};
		end
	end

	// Control: configuration, bounds, sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_en_q <= 1'b0;
			eye_q[0]  <= '0;
			eye_q[1]  <= '0;
			eye_q[2]  <= '0;
			near_q    <= '0;
			thr_q     <= '0;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			radius_q  <= '0;
			state_q   <= ST_IDLE;
			rnd_q     <= R_D00;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				unique case (wr_idx)
					REG_CULL_ENABLE: cull_en_q <= wr_data[0];
					REG_EYE_X:       eye_q[0]  <= EYE_BITS'(wr_data);
					REG_EYE_Y:       eye_q[1]  <= EYE_BITS'(wr_data);
					REG_EYE_Z:       eye_q[2]  <= EYE_BITS'(wr_data);
					REG_NEAR_KEEP:   near_q    <= wr_data[NEAR_BITS-1:0];
					REG_MIN_ANGLE:   thr_q     <= wr_data[THR_BITS-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.kind == KIND_BOUNDS) begin
							center_q[0] <= cmd.word0;
							center_q[1] <= cmd.word1;
							center_q[2] <= cmd.word2;
							radius_q    <= cmd.word3;
						end else if (cmd.group_index == GROUP_TRANSLATION) begin
							state_q <= ST_ISSUE;
							rnd_q   <= R_D00;
						end
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (lane_done[0]) begin
						if (rnd_q == R_FIN) begin
							state_q <= ST_DONE;
						end else begin
							rnd_q   <= rnd_q + 4'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					res_q   <= decision;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: matrix words, accumulators and round results
	always_ff @(posedge clk) begin
		if (accept && (cmd.kind == KIND_MATRIX)) begin
			case (cmd.group_index)
				GROUP_COL0: begin
					mat_q[0][0] <= cmd.word0;
					mat_q[0][1] <= cmd.word1;
					mat_q[0][2] <= cmd.word2;
				end
				GROUP_COL1: begin
					mat_q[1][0] <= cmd.word0;
					mat_q[1][1] <= cmd.word1;
					mat_q[1][2] <= cmd.word2;
				end
				GROUP_COL2: begin
					mat_q[2][0] <= cmd.word0;
					mat_q[2][1] <= cmd.word1;
					mat_q[2][2] <= cmd.word2;
				end
				default: begin
					// seed each coordinate with the eye-relative translation
					acc_q[0] <= AW'(EW'(cmd.word0) - EW'(eye_q[0])) <<< FRAC_BITS;
					acc_q[1] <= AW'(EW'(cmd.word1) - EW'(eye_q[1])) <<< FRAC_BITS;
					acc_q[2] <= AW'(EW'(cmd.word2) - EW'(eye_q[2])) <<< FRAC_BITS;
					row_q[0] <= '0;
					row_q[1] <= '0;
					row_q[2] <= '0;
				end
			endcase
		end
		if (merge) begin
			case (rnd_q)
				R_D00: row_q[0] <= row_q[0] + dot_abs;
				R_D01: begin
					row_q[0] <= row_q[0] + dot_abs;
					row_q[1] <= row_q[1] + dot_abs;
				end
				R_D02: begin
					row_q[0] <= row_q[0] + dot_abs;
					row_q[2] <= row_q[2] + dot_abs;
				end
				R_D11: row_q[1] <= row_q[1] + dot_abs;
				R_D12: begin
					row_q[1] <= row_q[1] + dot_abs;
					row_q[2] <= row_q[2] + dot_abs;
				end
				R_D22: row_q[2] <= row_q[2] + dot_abs;
				R_A0, R_A1, R_A2: begin
					for (int k = 0; k < 3; k++) begin
						acc_q[k] <= acc_q[k] + AW'(lane_p[k]);
					end
				end
				R_DIST: begin
					dist2_q <= dist_sum;
					bound_q <= bound_c;
				end
				R_SQ: begin
					r2_q    <= R2W'(lane_p[0]);
					near2_q <= N2W'(lane_p[1]);
					thr2_q  <= T2W'(lane_p[2]);
				end
				R_FIN: begin
					lhs_q <= P'(lane_p[0]);
					rhs_q <= P'(lane_p[2]);
				end
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`IASC_ASSERT(a_lanes_in_step, clk, arst_n, lane_done[0] |-> (lane_done == 3'b111), "lanes out of step")
	`IASC_ASSERT(a_result_when_idle, clk, arst_n, done_q |-> (state_q == ST_IDLE), "result while busy")
	`IASC_ASSERT_NEXT(a_translation_starts, clk, arst_n, accept && (cmd.kind == KIND_MATRIX) && (cmd.group_index == GROUP_TRANSLATION), state_q == ST_ISSUE, "translation transaction did not start rounds")

endmodule

`default_nettype wire

// File: bench/iasc_cull_checker.sv
// Checker for the angular size cull block: snoops config writes and commands,
// predicts each visibility verdict and compares it with the block's output.
// Depends on iasc_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 1ps
`default_nettype none

module iasc_cull_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  iasc_pkg::iasc_in_t                cmd,
	input  logic                              done,
	input  iasc_pkg::iasc_out_t               result,
	input  logic                              wr_en,
	input  logic [iasc_pkg::REG_IDX_BITS-1:0] wr_idx,
	input  logic [iasc_pkg::CFG_BITS-1:0]     wr_data,
	output int                                mismatch_count,
	output int                                verdicts_pending,
	output int                                verdicts_checked
);

	import iasc_pkg::*;

	localparam int FRAC_BITS_TB = 16;

	typedef logic signed [319:0] wide_t;

	// Shadow copy of the block's registers and stores
	logic                          cull_on;
	logic signed [EYE_BITS-1:0]    eye [3];
	logic [NEAR_BITS-1:0]          near_keep;
	logic [THR_BITS-1:0]           min_angle;
	logic signed [WORD_BITS-1:0]   center [3];
	logic signed [WORD_BITS-1:0]   radius;
	logic signed [WORD_BITS-1:0]   basis [12];

	iasc_out_t expected_verdicts [$];

	function automatic wide_t widen(input logic signed [WORD_BITS-1:0] v);
		return v;
	endfunction

	function automatic wide_t magnitude(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Work out the verdict for a translation group against the shadow state
	function automatic iasc_out_t judge_instance(input iasc_in_t c);
		iasc_out_t v;
		logic signed [WORD_BITS-1:0] t [3];
		wide_t bound, row, dot, r, acc, dist2, near2, lhs, rhs, thr;
		t[0] = c.word0;
		t[1] = c.word1;
		t[2] = c.word2;
		if (!cull_on) begin
			v.visible = 1'b1;
			v.decision_reason = REASON_DISABLED;
			return v;
		end
		bound = '0;
		for (int i = 0; i < 3; i++) begin
			row = '0;
			for (int j = 0; j < 3; j++) begin
				dot = '0;
				for (int k = 0; k < 3; k++)
					dot += widen(basis[4*i+k]) * widen(basis[4*j+k]);
				row += magnitude(dot);
			end
			if (row > bound)
				bound = row;
		end
		r = widen(radius);
		if (r <= 0 || bound == 0) begin
			v.visible = 1'b1;
			v.decision_reason = REASON_NO_BOUNDS;
			return v;
		end
		dist2 = '0;
		for (int k = 0; k < 3; k++) begin
			acc = (widen(t[k]) - widen(eye[k])) <<< FRAC_BITS_TB;
			for (int i = 0; i < 3; i++)
				acc += widen(basis[4*i+k]) * widen(center[i]);
			dist2 += acc * acc;
		end
		near2 = wide_t'({1'b0, near_keep});
		near2 = (near2 * near2) <<< (2 * FRAC_BITS_TB);
		if (dist2 <= near2) begin
			v.visible = 1'b1;
			v.decision_reason = REASON_NEAR;
			return v;
		end
		thr = wide_t'({1'b0, min_angle});
		lhs = (r * r * bound) <<< 32;
		rhs = thr * thr * dist2;
		if (lhs >= rhs) begin
			v.visible = 1'b1;
			v.decision_reason = REASON_LARGE;
		end else begin
			v.visible = 1'b0;
			v.decision_reason = REASON_SMALL;
		end
		return v;
	endfunction

	// Compare strobed verdicts, track config and commands, predict translations
	always @(posedge clk or negedge arst_n) begin
		iasc_out_t want;
		if (!arst_n) begin
			cull_on = 1'b0;
			for (int i = 0; i < 3; i++) begin
				eye[i] = '0;
				center[i] = '0;
			end
			for (int i = 0; i < 12; i++)
				basis[i] = '0;
			near_keep = '0;
			min_angle = '0;
			radius = '0;
			expected_verdicts.delete();
			verdicts_pending = 0;
		end else begin
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected verdict visible=%0b reason=%0d", $time,
						result.visible, result.decision_reason);
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_checked++;
					if (want.visible !== result.visible ||
					    want.decision_reason !== result.decision_reason) begin
						$display("%0t: verdict mismatch expected visible=%0b reason=%0d,",
							$time, want.visible, want.decision_reason);
						$display("%0t:   got visible=%0b reason=%0d", $time,
							result.visible, result.decision_reason);
						mismatch_count++;
					end
				end
			end
			if (wr_en) begin
				case (wr_idx)
					REG_CULL_ENABLE: cull_on = wr_data[0];
					REG_EYE_X:       eye[0] = wr_data[EYE_BITS-1:0];
					REG_EYE_Y:       eye[1] = wr_data[EYE_BITS-1:0];
					REG_EYE_Z:       eye[2] = wr_data[EYE_BITS-1:0];
					REG_NEAR_KEEP:   near_keep = wr_data[NEAR_BITS-1:0];
					REG_MIN_ANGLE:   min_angle = wr_data[THR_BITS-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd.kind == KIND_BOUNDS) begin
					center[0] = cmd.word0;
					center[1] = cmd.word1;
					center[2] = cmd.word2;
					radius = cmd.word3;
				end else if (cmd.group_index == GROUP_TRANSLATION) begin
					expected_verdicts.push_back(judge_instance(cmd));
				end else begin
					basis[4*cmd.group_index+0] = cmd.word0;
					basis[4*cmd.group_index+1] = cmd.word1;
					basis[4*cmd.group_index+2] = cmd.word2;
					basis[4*cmd.group_index+3] = cmd.word3;
				end
			end
			verdicts_pending = expected_verdicts.size();
		end
	end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench top for the angular size cull block: clock, reset, config phases
// and command stimulus; the checker module does all prediction and comparison.
// Depends on iasc_pkg, instance_angular_size_cull and iasc_cull_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import iasc_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	iasc_in_t                cmd = '0;
	logic                    done;
	iasc_out_t               result;
	logic                    wr_en = 1'b0;
	logic [REG_IDX_BITS-1:0] wr_idx = '0;
	logic [CFG_BITS-1:0]     wr_data = '0;
	int                      mismatch_count, verdicts_pending, verdicts_checked;
	int                      items_sent = 0;
	bit                      steady = 0;

	always #2 clk = ~clk;

	instance_angular_size_cull i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	iasc_cull_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.mismatch_count(mismatch_count), .verdicts_pending(verdicts_pending),
		.verdicts_checked(verdicts_checked)
	);

	// Hold one transaction until accepted; start stays high for the next call
	task automatic send(input logic kind, input logic [1:0] grp,
			input logic [31:0] w0, w1, w2, w3);
		if (!steady && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{kind, grp, w0, w1, w2, w3};
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] data);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Stop sending and wait until every verdict is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic en, input logic [31:0] ex, ey, ez,
			input logic [30:0] nk, input logic [15:0] thr);
		write_reg(REG_CULL_ENABLE, {31'b0, en});
		write_reg(REG_EYE_X, ex);
		write_reg(REG_EYE_Y, ey);
		write_reg(REG_EYE_Z, ez);
		write_reg(REG_NEAR_KEEP, {1'b0, nk});
		write_reg(REG_MIN_ANGLE, {16'b0, thr});
	endtask

	function automatic logic [31:0] span(input int half);
		return $urandom_range(0, 2 * half) - half;
	endfunction

	// Basis entry: mostly about unit scale, sometimes zero or full range
	function automatic logic [31:0] basis_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return 32'h0;
		if (pick < 14)
			return $urandom;
		return span(1 << 18);
	endfunction

	task automatic send_group(input logic [1:0] grp);
		send(KIND_MATRIX, grp, basis_word(), basis_word(), basis_word(), $urandom);
	endtask

	task automatic send_bounds();
		logic [31:0] rad;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			rad = 32'h0;
		else if (pick < 16)
			rad = -$urandom_range(1, 1 << 20);
		else if (pick < 24)
			rad = $urandom;
		else
			rad = $urandom_range(1, 1 << 19);
		if ($urandom_range(9) == 0)
			send(KIND_BOUNDS, 2'($urandom), $urandom, $urandom, $urandom, rad);
		else
			send(KIND_BOUNDS, 2'($urandom), span(1 << 18), span(1 << 18),
				span(1 << 18), rad);
	endtask

	task automatic send_translation();
		if ($urandom_range(9) == 0)
			send(KIND_MATRIX, GROUP_TRANSLATION, $urandom, $urandom, $urandom, $urandom);
		else
			send(KIND_MATRIX, GROUP_TRANSLATION, span(1 << 24), span(1 << 24),
				span(1 << 24), $urandom);
	endtask

	// Mostly whole instances with random content; the rest partial or stray items
	task automatic random_traffic(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(99) < 25)
					send_bounds();
				if ($urandom_range(99) < 90) begin
					send_group(GROUP_COL0);
					send_group(GROUP_COL1);
					send_group(GROUP_COL2);
				end else begin
					repeat ($urandom_range(1, 3)) send_group(2'($urandom_range(0, 2)));
				end
				send_translation();
			end else begin
				case ($urandom_range(3))
					0: send_bounds();
					1: send_group(2'($urandom_range(0, 2)));
					2: send_translation();
					default: send(KIND_MATRIX, 2'($urandom), $urandom, $urandom,
						$urandom, $urandom);
				endcase
			end
		end
	endtask

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Culling disabled out of reset: every instance kept
		send(KIND_MATRIX, GROUP_COL0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF);
		send(KIND_MATRIX, GROUP_COL1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0);
		send(KIND_MATRIX, GROUP_COL2, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0);
		drain();

		// Directed cases with unit scale, eye at origin, threshold 2^-8
		configure(1'b1, 0, 0, 0, 31'd0, 16'd256);
		send(KIND_BOUNDS, GROUP_COL2, 0, 0, 0, 32'd1);
		send(KIND_MATRIX, GROUP_COL0, 32'h10000, 0, 0, 0);
		send(KIND_MATRIX, GROUP_COL1, 0, 32'h10000, 0, 0);
		send(KIND_MATRIX, GROUP_COL2, 0, 0, 32'h10000, 0);
		// radius exactly at the threshold is kept, one step farther is culled
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'd256, 0, 0, 0);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'd257, 0, 0, 0);
		// camera at the centre falls in the near field even with zero distance
		send(KIND_MATRIX, GROUP_TRANSLATION, 0, 0, 0, 0);
		// zero and negative radius give no bounds
		send(KIND_BOUNDS, GROUP_COL0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h100000, 0, 0, 0);
		send(KIND_BOUNDS, GROUP_TRANSLATION, 32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h100000, 0, 0, 0);
		// zero basis gives no bounds despite a good radius
		send(KIND_BOUNDS, GROUP_COL1, 0, 0, 0, 32'h7FFFFFFF);
		send(KIND_MATRIX, GROUP_COL0, 0, 0, 0, 32'h7FFFFFFF);
		send(KIND_MATRIX, GROUP_COL1, 0, 0, 0, 32'h80000000);
		send(KIND_MATRIX, GROUP_COL2, 0, 0, 0, 32'hFFFFFFFF);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h100000, 0, 0, 0);
		// extreme basis words, reused by a second translation
		send(KIND_MATRIX, GROUP_COL0, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
		send(KIND_MATRIX, GROUP_TRANSLATION, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		random_traffic(150);
		drain();

		configure(1'b1, span(1 << 22), span(1 << 22), span(1 << 22), 31'h100000, 16'd2000);
		random_traffic(160);
		drain();

		// Extreme eye and thresholds, sender never idles
		steady = 1;
		configure(1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 16'hFFFF);
		random_traffic(80);
		drain();
		configure(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'd0, 16'hFFFF);
		random_traffic(80);
		drain();
		steady = 0;

		configure(1'b1, 0, 0, 0, 31'd0, 16'd0);
		random_traffic(160);
		drain();

		configure(1'b1, $urandom, $urandom, $urandom, 31'($urandom), 16'($urandom));
		random_traffic(160);
		drain();

		configure(1'b1, span(1 << 20), span(1 << 20), span(1 << 20), 31'h40000, 16'd300);
		random_traffic(200);
		drain();

		// Writes to unused indexes must be ignored
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		configure(1'b1, span(1 << 16), span(1 << 16), span(1 << 16), 31'h10000, 16'd800);
		random_traffic(160);
		drain();

		write_reg(REG_CULL_ENABLE, 32'h0);
		random_traffic(100);
		drain();

		repeat (20) @(posedge clk);
		$display("Sent %0d commands over ten register settings; checked %0d verdicts.",
			items_sent, verdicts_checked);
		$display("Covered disabled, no-bounds, near-field, culled and kept decisions.");
		if (mismatch_count == 0 && verdicts_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/iasc_pkg.sv
rtl/iasc_mul_lane.sv
rtl/instance_angular_size_cull.sv
bench/iasc_cull_checker.sv
bench/tb.sv
